// ----- rtl/wlss_pkg.sv -----
// Shared types and constants for the web log stream statistics block.
// Used by the top level; no dependencies of its own.
package wlss_pkg;

    // Field widths of one log record beat and of one result beat.
    localparam int unsigned TS_W      = 32;
    localparam int unsigned ID_W      = 32;
    localparam int unsigned SIZE_W    = 32;
    localparam int unsigned SERVER_W  = 8;
    localparam int unsigned SEL_W     = 4;
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned DISTINCT_W = 9;

    // Packed widths of the slave-side tdata and tuser.
    localparam int unsigned S_TDATA_W = TS_W + 2 * ID_W + SIZE_W + SERVER_W;
    localparam int unsigned S_TUSER_W = 1 + SEL_W;

    // Size code that marks an unknown transfer size.
    localparam logic [SIZE_W-1:0] SIZE_UNKNOWN = '1;

    // Record command carried in tuser.
    typedef enum logic {
        CMD_ACCUM = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    // Statistic selector for a read command.
    typedef enum logic [SEL_W-1:0] {
        SEL_REQUESTS    = 4'd0,
        SEL_BYTES       = 4'd1,
        SEL_DISORDER    = 4'd2,
        SEL_DISTINCT    = 4'd3,
        SEL_TIME_LOW    = 4'd4,
        SEL_TIME_HIGH   = 4'd5,
        SEL_SIZE_LOW    = 4'd6,
        SEL_SIZE_HIGH   = 4'd7,
        SEL_OBJECT_LOW  = 4'd8,
        SEL_OBJECT_HIGH = 4'd9,
        SEL_CLIENT_LOW  = 4'd10,
        SEL_CLIENT_HIGH = 4'd11,
        SEL_PREV_TIME   = 4'd12,
        SEL_HISTOGRAM   = 4'd13
    } t_stat_sel;

endpackage

// ----- rtl/wlss_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; a read of an address written in the same cycle returns the old data.
module wlss_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/web_log_stream_statistics.sv -----
// Top level of the web log stream statistics block.
// Depends on wlss_pkg and wlss_ram.
//
// The block takes one log record or read command per clock on the slave stream and
// sustains one beat per cycle while the master side takes results. A read result
// passes through the execute stage and the output register onto the master stream
// and is held there until taken. Accumulate records keep flowing in meanwhile; a
// second read waits in the execute stage and holds off the input until the first
// result is taken. The per-server histogram sits in one RAM with a registered read:
// a record reads its entry when accepted and the next cycle adds one and writes it
// back, with the value being written forwarded to a following beat for the same
// server. Histogram entries are marked valid in flip-flops that reset clears, so the
// block is ready right after reset with no clearing pass. Only read commands produce
// a result beat; accumulate records produce none.
module web_log_stream_statistics
    import wlss_pkg::*;
#(
    parameter int unsigned SERVER_ENTRIES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [31:0] timestamp, [63:32] client, [95:64] object, [127:96] size,
    // [135:128] server
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] command, [4:1] stat_select
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [63:0] read_value
    output logic [VALUE_W-1:0]   m_axis_tdata
);

    // Only server indexes the field can carry are ever stored.
    localparam int unsigned HIST_DEPTH =
        (SERVER_ENTRIES > (1 << SERVER_W)) ? (1 << SERVER_W) : SERVER_ENTRIES;
    localparam int unsigned HIST_AW = $clog2(HIST_DEPTH);

    // Slave beat fields.
    logic [TS_W-1:0]     s_ts;
    logic [ID_W-1:0]     s_client;
    logic [ID_W-1:0]     s_object;
    logic [SIZE_W-1:0]   s_size;
    logic [SERVER_W-1:0] s_server;
    t_cmd                s_cmd;
    logic [SEL_W-1:0]    s_sel;
    logic                s_in_range;
    logic                s_accept;

    assign s_ts     = s_axis_tdata[TS_W-1:0];
    assign s_client = s_axis_tdata[TS_W +: ID_W];
    assign s_object = s_axis_tdata[TS_W + ID_W +: ID_W];
    assign s_size   = s_axis_tdata[TS_W + 2 * ID_W +: SIZE_W];
    assign s_server = s_axis_tdata[TS_W + 2 * ID_W + SIZE_W +: SERVER_W];
    assign s_cmd    = t_cmd'(s_axis_tuser[0]);
    assign s_sel    = s_axis_tuser[S_TUSER_W-1:1];
    assign s_in_range = (32'(s_server) < 32'(SERVER_ENTRIES));

    // Execute stage registers.
    logic                r_s1_valid;
    t_cmd                r_s1_cmd;
    logic [TS_W-1:0]     r_s1_ts;
    logic [ID_W-1:0]     r_s1_client;
    logic [ID_W-1:0]     r_s1_object;
    logic [SIZE_W-1:0]   r_s1_size;
    logic [HIST_AW-1:0]  r_s1_addr;
    logic                r_s1_in_range;
    logic [SEL_W-1:0]    r_s1_sel;
    logic                r_s1_fwd;
    logic [COUNT_W-1:0]  r_s1_fwd_data;

    // Statistics registers.
    logic [COUNT_W-1:0]    r_requests;
    logic [VALUE_W-1:0]    r_bytes;
    logic [COUNT_W-1:0]    r_disorder;
    logic [TS_W-1:0]       r_prev_time;
    logic [TS_W-1:0]       r_time_low;
    logic [TS_W-1:0]       r_time_high;
    logic [SIZE_W-1:0]     r_size_low;
    logic [SIZE_W-1:0]     r_size_high;
    logic [ID_W-1:0]       r_object_low;
    logic [ID_W-1:0]       r_object_high;
    logic [ID_W-1:0]       r_client_low;
    logic [ID_W-1:0]       r_client_high;
    logic [DISTINCT_W-1:0] r_distinct;
    logic [HIST_DEPTH-1:0] r_hit_valid;

    // Output register.
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_data;
    logic [VALUE_W-1:0]  n_out_data;

    // Pipeline control.
    logic out_free;
    logic s1_fire;
    logic advance;
    logic s1_accum;
    logic s1_read;

    // Histogram access.
    logic               hist_wr_en;
    logic [COUNT_W-1:0] hist_rd_data;
    logic [COUNT_W-1:0] hist_old;
    logic [COUNT_W-1:0] hist_new;

    assign out_free = !r_out_valid || m_axis_tready;
    assign s1_fire  = r_s1_valid && ((r_s1_cmd == CMD_ACCUM) || out_free);
    assign advance  = !r_s1_valid || s1_fire;
    assign s_axis_tready = advance;
    assign s_accept = s_axis_tvalid && advance;
    assign s1_accum = s1_fire && (r_s1_cmd == CMD_ACCUM);
    assign s1_read  = s1_fire && (r_s1_cmd == CMD_READ);

    wlss_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hist_wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (hist_new),
        .i_rd_en   (s_accept),
        .i_rd_addr (s_server[HIST_AW-1:0]),
        .o_rd_data (hist_rd_data)
    );

    // Current histogram entry: forwarded write, RAM data, or zero if never written.
    always_comb begin
        if (r_s1_fwd) begin
            hist_old = r_s1_fwd_data;
        end else if (r_hit_valid[r_s1_addr]) begin
            hist_old = hist_rd_data;
        end else begin
            hist_old = '0;
        end
    end

    assign hist_new   = hist_old + COUNT_W'(1);
    assign hist_wr_en = s1_accum && r_s1_in_range;

    // Execute stage capture, with forwarding of a write to the entry being read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= s_axis_tvalid;
        end
        if (s_accept) begin
            r_s1_cmd      <= s_cmd;
            r_s1_ts       <= s_ts;
            r_s1_client   <= s_client;
            r_s1_object   <= s_object;
            r_s1_size     <= s_size;
            r_s1_addr     <= s_server[HIST_AW-1:0];
            r_s1_in_range <= s_in_range;
            r_s1_sel      <= s_sel;
            r_s1_fwd      <= hist_wr_en && (r_s1_addr == s_server[HIST_AW-1:0]);
            r_s1_fwd_data <= hist_new;
        end
    end

    // Statistics update for an accumulate record.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_requests    <= '0;
            r_bytes       <= '0;
            r_disorder    <= '0;
            r_prev_time   <= '0;
            r_time_low    <= '1;
            r_time_high   <= '0;
            r_size_low    <= '1;
            r_size_high   <= '0;
            r_object_low  <= '1;
            r_object_high <= '0;
            r_client_low  <= '1;
            r_client_high <= '0;
            r_distinct    <= '0;
            r_hit_valid   <= '0;
        end else if (s1_accum) begin
            r_requests <= r_requests + COUNT_W'(1);
            if (r_s1_size != SIZE_UNKNOWN) begin
                r_bytes <= r_bytes + VALUE_W'($signed(r_s1_size));
                if (r_s1_size < r_size_low) begin
                    r_size_low <= r_s1_size;
                end
                if (r_s1_size > r_size_high) begin
                    r_size_high <= r_s1_size;
                end
            end
            if ($signed(r_s1_ts) < $signed(r_prev_time)) begin
                r_disorder <= r_disorder + COUNT_W'(1);
            end
            r_prev_time <= r_s1_ts;
            if (r_s1_ts < r_time_low) begin
                r_time_low <= r_s1_ts;
            end
            if (r_s1_ts > r_time_high) begin
                r_time_high <= r_s1_ts;
            end
            if (r_s1_object < r_object_low) begin
                r_object_low <= r_s1_object;
            end
            if (r_s1_object > r_object_high) begin
                r_object_high <= r_s1_object;
            end
            if (r_s1_client < r_client_low) begin
                r_client_low <= r_s1_client;
            end
            if (r_s1_client > r_client_high) begin
                r_client_high <= r_s1_client;
            end
            if (r_s1_in_range) begin
                r_hit_valid[r_s1_addr] <= 1'b1;
                if (hist_old == '0) begin
                    r_distinct <= r_distinct + DISTINCT_W'(1);
                end
            end
        end
    end

    // Read selection.
    always_comb begin
        unique case (t_stat_sel'(r_s1_sel))
            SEL_REQUESTS:    n_out_data = VALUE_W'(r_requests);
            SEL_BYTES:       n_out_data = r_bytes;
            SEL_DISORDER:    n_out_data = VALUE_W'(r_disorder);
            SEL_DISTINCT:    n_out_data = VALUE_W'(r_distinct);
            SEL_TIME_LOW:    n_out_data = VALUE_W'(r_time_low);
            SEL_TIME_HIGH:   n_out_data = VALUE_W'(r_time_high);
            SEL_SIZE_LOW:    n_out_data = VALUE_W'(r_size_low);
            SEL_SIZE_HIGH:   n_out_data = VALUE_W'(r_size_high);
            SEL_OBJECT_LOW:  n_out_data = VALUE_W'(r_object_low);
            SEL_OBJECT_HIGH: n_out_data = VALUE_W'(r_object_high);
            SEL_CLIENT_LOW:  n_out_data = VALUE_W'(r_client_low);
            SEL_CLIENT_HIGH: n_out_data = VALUE_W'(r_client_high);
            SEL_PREV_TIME:   n_out_data = VALUE_W'(r_prev_time);
            SEL_HISTOGRAM:   n_out_data = r_s1_in_range ? VALUE_W'(hist_old) : '0;
            default:         n_out_data = '0;
        endcase
    end

    // Output register; it is refilled in the same cycle it is drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_read) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_read) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for web_log_stream_statistics: a directed table, then random traffic.
// Needs wlss_pkg and the block's RTL; read beats are checked against a running statistics model.
module tb_top;
    import wlss_pkg::*;

    localparam int unsigned SERVER_COUNT  = 256;
    localparam int unsigned RESET_CYCLES  = 7;
    localparam int unsigned RANDOM_ITEMS  = 1800;
    localparam int unsigned HOLD_AFTER    = 50;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned TAIL_CYCLES   = 8;
    localparam int unsigned STALL_LIMIT   = 2000;

    // Selector codes outside the defined statistics; both read as zero.
    localparam logic [SEL_W-1:0] SEL_UNUSED_LO = 4'd14;
    localparam logic [SEL_W-1:0] SEL_UNUSED_HI = 4'd15;

    // One input beat, split into its fields.
    typedef struct packed {
        t_cmd                cmd;
        logic [SEL_W-1:0]    sel;
        logic [SERVER_W-1:0] server;
        logic [TS_W-1:0]     timestamp;
        logic [ID_W-1:0]     client;
        logic [ID_W-1:0]     object;
        logic [SIZE_W-1:0]   size;
    } t_beat;

    // A row of the directed table; typed rows carry their expected read value.
    typedef struct packed {
        t_beat              beat;
        logic               typed;
        logic [VALUE_W-1:0] value;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [31:0] timestamp, [63:32] client, [95:64] object, [127:96] size,
    // [135:128] server
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // [0] command, [4:1] stat_select
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [63:0] read_value
    logic [VALUE_W-1:0]   m_axis_tdata;

    web_log_stream_statistics #(
        .SERVER_ENTRIES(SERVER_COUNT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Running statistics as the block should hold them.
    logic [COUNT_W-1:0]    seen_requests;
    logic [VALUE_W-1:0]    seen_bytes;
    logic [COUNT_W-1:0]    seen_disorder;
    logic [TS_W-1:0]       seen_prev_time;
    logic [TS_W-1:0]       time_lo, time_hi;
    logic [SIZE_W-1:0]     size_lo, size_hi;
    logic [ID_W-1:0]       object_lo, object_hi;
    logic [ID_W-1:0]       client_lo, client_hi;
    logic [COUNT_W-1:0]    hits_per_server [SERVER_COUNT];
    logic [DISTINCT_W-1:0] seen_servers;

    // Read values owed by the block, oldest first.
    logic [VALUE_W-1:0] pending_reads [$];
    t_row               directed_rows [$];

    int unsigned n_failures    = 0;
    int unsigned reads_checked = 0;
    int unsigned n_records     = 0;
    int unsigned n_reads       = 0;
    int unsigned tx_sent       = 0;
    bit          tx_calm       = 1'b0;
    bit          rx_calm       = 1'b0;
    bit          hold_done     = 1'b0;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Applies one beat to the statistics; returns 1 with the read value for a read.
    function automatic bit predict_beat(input t_beat b, output logic [VALUE_W-1:0] value);
        value = '0;
        if (b.cmd == CMD_READ) begin
            case (b.sel)
                SEL_REQUESTS:    value = VALUE_W'(seen_requests);
                SEL_BYTES:       value = seen_bytes;
                SEL_DISORDER:    value = VALUE_W'(seen_disorder);
                SEL_DISTINCT:    value = VALUE_W'(seen_servers);
                SEL_TIME_LOW:    value = VALUE_W'(time_lo);
                SEL_TIME_HIGH:   value = VALUE_W'(time_hi);
                SEL_SIZE_LOW:    value = VALUE_W'(size_lo);
                SEL_SIZE_HIGH:   value = VALUE_W'(size_hi);
                SEL_OBJECT_LOW:  value = VALUE_W'(object_lo);
                SEL_OBJECT_HIGH: value = VALUE_W'(object_hi);
                SEL_CLIENT_LOW:  value = VALUE_W'(client_lo);
                SEL_CLIENT_HIGH: value = VALUE_W'(client_hi);
                SEL_PREV_TIME:   value = VALUE_W'(seen_prev_time);
                SEL_HISTOGRAM:   value = (int'(b.server) < SERVER_COUNT) ?
                                         VALUE_W'(hits_per_server[b.server]) : '0;
                default:         value = '0;
            endcase
            return 1'b1;
        end
        seen_requests = seen_requests + COUNT_W'(1);
        // An unknown size leaves the byte total and the size extremes alone.
        if (b.size != SIZE_UNKNOWN) begin
            seen_bytes = seen_bytes + {{32{b.size[SIZE_W-1]}}, b.size};
            if (b.size < size_lo) size_lo = b.size;
            if (b.size > size_hi) size_hi = b.size;
        end
        if ($signed(b.timestamp) < $signed(seen_prev_time)) begin
            seen_disorder = seen_disorder + COUNT_W'(1);
        end
        seen_prev_time = b.timestamp;
        if (b.timestamp < time_lo) time_lo = b.timestamp;
        if (b.timestamp > time_hi) time_hi = b.timestamp;
        if (b.object < object_lo) object_lo = b.object;
        if (b.object > object_hi) object_hi = b.object;
        if (b.client < client_lo) client_lo = b.client;
        if (b.client > client_hi) client_hi = b.client;
        if (int'(b.server) < SERVER_COUNT) begin
            if (hits_per_server[b.server] == '0) seen_servers = seen_servers + DISTINCT_W'(1);
            hits_per_server[b.server] = hits_per_server[b.server] + COUNT_W'(1);
        end
        return 1'b0;
    endfunction

    task automatic add_row(input t_cmd cmd, input logic [SEL_W-1:0] sel,
                           input logic [SERVER_W-1:0] server, input logic [TS_W-1:0] ts,
                           input logic [ID_W-1:0] cli, input logic [ID_W-1:0] obj,
                           input logic [SIZE_W-1:0] sz, input logic typed,
                           input logic [VALUE_W-1:0] value);
        t_row r;
        r.beat  = '{cmd: cmd, sel: sel, server: server, timestamp: ts,
                    client: cli, object: obj, size: sz};
        r.typed = typed;
        r.value = value;
        directed_rows.push_back(r);
    endtask

    // Offers one beat after a random gap and records what it should produce.
    task automatic send_beat(input t_beat b, input logic typed, input logic [VALUE_W-1:0] fixed);
        int unsigned        gap;
        logic [VALUE_W-1:0] value;
        if (tx_sent % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.server, b.size, b.object, b.client, b.timestamp};
        s_axis_tuser  <= {b.sel, b.cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_beat(b, value)) pending_reads.push_back(typed ? fixed : value);
        tx_sent++;
        if (b.cmd == CMD_READ) n_reads++;
        else n_records++;
    endtask

    // Stops offering beats until every owed read value has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_reads.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus: reset, the directed table, then random records and reads.
    initial begin : stimulus
        t_beat       b;
        logic [TS_W-1:0] clock_now;
        seen_requests  = '0;
        seen_bytes     = '0;
        seen_disorder  = '0;
        seen_prev_time = '0;
        time_lo        = '1;
        time_hi        = '0;
        size_lo        = '1;
        size_hi        = '0;
        object_lo      = '1;
        object_hi      = '0;
        client_lo      = '1;
        client_hi      = '0;
        seen_servers   = '0;
        for (int i = 0; i < SERVER_COUNT; i++) hits_per_server[i] = '0;

        // Fields: cmd, sel, server, timestamp, client, object, size, typed, expected value.
        add_row(CMD_READ,  SEL_REQUESTS,    8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 64'h0);
        add_row(CMD_READ,  SEL_TIME_LOW,    8'h00, 32'h0, 32'h0, 32'h0, 32'h0,
                1'b1, 64'hFFFF_FFFF);
        add_row(CMD_READ,  SEL_SIZE_HIGH,   8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 64'h0);
        add_row(CMD_READ,  SEL_HISTOGRAM,   8'hFF, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 64'h0);
        add_row(CMD_READ,  SEL_UNUSED_HI,   8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'h0);
        add_row(CMD_ACCUM, SEL_REQUESTS,    8'h00, 32'h7FFF_FFFF, 32'h0,
                32'hFFFF_FFFF, SIZE_UNKNOWN, 1'b0, 64'h0);
        add_row(CMD_ACCUM, SEL_REQUESTS,    8'hFF, 32'h8000_0000, 32'hFFFF_FFFF,
                32'h0, 32'h7FFF_FFFF, 1'b0, 64'h0);
        add_row(CMD_ACCUM, SEL_REQUESTS,    8'h00, 32'h0, 32'h1234_5678,
                32'h89AB_CDEF, 32'h8000_0000, 1'b0, 64'h0);
        add_row(CMD_ACCUM, SEL_REQUESTS,    8'hFF, 32'h1, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_REQUESTS,    8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_BYTES,       8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_DISORDER,    8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_DISTINCT,    8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_TIME_LOW,    8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_TIME_HIGH,   8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_SIZE_LOW,    8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_SIZE_HIGH,   8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_OBJECT_LOW,  8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_OBJECT_HIGH, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_CLIENT_LOW,  8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_CLIENT_HIGH, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_PREV_TIME,   8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_HISTOGRAM,   8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_HISTOGRAM,   8'hFF, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0);
        add_row(CMD_READ,  SEL_UNUSED_LO,   8'h5A, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 64'h0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].value);
        drain_results();

        // Random part: timestamps mostly advance, with jumps backward and anywhere.
        clock_now = $urandom;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) drain_results();
            b.cmd = ($urandom_range(0, 9) < 4) ? CMD_READ : CMD_ACCUM;
            b.sel = SEL_W'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
                0:       b.timestamp = $urandom;
                1:       b.timestamp = clock_now - $urandom_range(1, 1000);
                default: b.timestamp = clock_now + $urandom_range(0, 50);
            endcase
            if (b.cmd == CMD_ACCUM) clock_now = b.timestamp;
            b.client = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
            b.object = $urandom;
            case ($urandom_range(0, 7))
                0:       b.size = SIZE_UNKNOWN;
                1, 2:    b.size = $urandom;
                default: b.size = $urandom_range(0, 65535);
            endcase
            // Half the records go to a few busy servers so entries build up.
            b.server = SERVER_W'($urandom_range(0, 1) ? $urandom_range(0, 7) :
                                                        $urandom_range(0, 255));
            send_beat(b, 1'b0, '0);
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d records and %0d reads; %0d read beats compared, with idle gaps",
                 n_records, n_reads, reads_checked);
        $display("on both sides and one long output stall.");
        if (n_failures == 0 && pending_reads.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Output side: random ready gaps, calm stretches, and one long hold-off.
    initial begin : receiver
        int unsigned gap;
        int unsigned taken;
        taken = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            if (!hold_done && taken == HOLD_AFTER) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end
            if (taken % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            gap = rx_calm ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            taken++;
        end
    end

    // Each accepted read beat is compared with the oldest owed value.
    always @(posedge i_clk) begin
        logic [VALUE_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_reads.size() == 0) begin
                $error("unexpected result beat: read_value %h", m_axis_tdata);
                n_failures++;
            end else begin
                want = pending_reads.pop_front();
                reads_checked++;
                if (m_axis_tdata !== want) begin
                    $error("read_value mismatch: expected %h, actual %h", want, m_axis_tdata);
                    n_failures++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither side has moved a beat for too long.
    always @(posedge i_clk) begin
        int unsigned idle_cycles;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

endmodule
